// File: src/lkv_pkg.sv
package lkv_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic signed [31:0] MISS_VALUE = -32'sd1;

  typedef struct packed {
    logic               op;
    logic signed [31:0] key;
    logic signed [31:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
  } out_item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DECIDE,
    BK_UPDATE,
    BK_FINISH
  } bk_state_t;

endpackage

// File: src/lkv_front.sv
module lkv_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  lkv_pkg::in_item_t in_data,
  output logic             q_valid,
  input  logic             q_take,
  output lkv_pkg::in_item_t q_data
);
  import lkv_pkg::*;

  in_item_t   slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign pop      = q_take && q_valid;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= in_data;
    end
  end

endmodule

// File: src/lkv_back.sv
module lkv_back #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  lkv_pkg::in_item_t            q_data,
  output logic                         q_take,
  input  logic [lkv_pkg::CAP_W-1:0]    capacity,
  output logic                         out_valid,
  input  logic                         out_stall,
  output lkv_pkg::out_item_t           out_data,
  output logic [$clog2(ENTRIES+1)-1:0] used_count,
  output logic [ENTRIES-1:0]           entry_valid
);
  import lkv_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int MW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [CW-1:0] LAST = CW'(ENTRIES);

  logic signed [31:0] key_mem  [ENTRIES];
  logic signed [31:0] val_mem  [ENTRIES];
  logic [IW-1:0]      rank_mem [ENTRIES];

  bk_state_t          state_r, state_nxt;
  logic [CW-1:0]      cnt_r;
  logic               rd_v_r;
  logic [IW-1:0]      rd_idx_r;
  in_item_t           item_r;
  logic signed [31:0] key_q, val_q;
  logic [IW-1:0]      rank_q;
  logic               hit_r, free_v_r, lru_v_r, fill_r, upd_r;
  logic [IW-1:0]      found_r, found_rank_r, free_r, lru_r, worst_r, slot_r, thr_r;
  logic [ENTRIES-1:0] valid_r;
  logic [CW-1:0]      used_r;
  logic               out_v_r;
  out_item_t          out_r;

  logic               issue, scan_done, fin;
  logic [MW-1:0]      eff_cap;
  logic               rank_we;
  logic [IW-1:0]      rank_wa, rank_wd;
  logic               fill_d;

  assign used_count  = used_r;
  assign entry_valid = valid_r;
  assign out_valid   = out_v_r;
  assign out_data    = out_r;
  assign scan_done   = (cnt_r == LAST) && !rd_v_r;

  always_comb begin
    eff_cap = MW'(capacity);
    if (eff_cap == '0) begin
      eff_cap = MW'(1);
    end else if (eff_cap > MW'(ENTRIES)) begin
      eff_cap = MW'(ENTRIES);
    end
  end

  assign fill_d = free_v_r && (MW'(used_r) < eff_cap);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:   if (q_valid) state_nxt = BK_SCAN;
      BK_SCAN:   if (scan_done) state_nxt = BK_DECIDE;
      BK_DECIDE: state_nxt = BK_UPDATE;
      BK_UPDATE: if (scan_done) state_nxt = BK_FINISH;
      BK_FINISH: if (!out_v_r || !out_stall) state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_take = 1'b0;
    issue  = 1'b0;
    fin    = 1'b0;
    unique case (state_r)
      BK_IDLE:   q_take = q_valid;
      BK_SCAN:   issue = (cnt_r != LAST);
      BK_DECIDE: ;
      BK_UPDATE: issue = (cnt_r != LAST);
      BK_FINISH: fin = !out_v_r || !out_stall;
      default:   ;
    endcase
  end

  // rank write: age entries during update, zero the touched slot at finish
  always_comb begin
    rank_we = 1'b0;
    rank_wa = slot_r;
    rank_wd = '0;
    if (fin) begin
      rank_we = upd_r;
    end else if (state_r == BK_UPDATE && rd_v_r && upd_r && valid_r[rd_idx_r]
                 && rd_idx_r != slot_r && (fill_r || rank_q < thr_r)) begin
      rank_we = 1'b1;
      rank_wa = rd_idx_r;
      rank_wd = rank_q + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      cnt_r   <= '0;
      rd_v_r  <= 1'b0;
      valid_r <= '0;
      used_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= issue;
      if (issue) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (state_r == BK_IDLE || state_r == BK_DECIDE) begin
        cnt_r <= '0;
      end
      if (fin && item_r.op == OP_PUT && !hit_r && fill_r) begin
        valid_r[slot_r] <= 1'b1;
        used_r          <= used_r + CW'(1);
      end
      if (fin) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r[IW-1:0];
    if (q_take) begin
      item_r   <= q_data;
      hit_r    <= 1'b0;
      free_v_r <= 1'b0;
      lru_v_r  <= 1'b0;
    end
    if (state_r == BK_SCAN && rd_v_r) begin
      if (valid_r[rd_idx_r] && key_q == item_r.key && !hit_r) begin
        hit_r        <= 1'b1;
        found_r      <= rd_idx_r;
        found_rank_r <= rank_q;
      end
      if (!valid_r[rd_idx_r] && !free_v_r) begin
        free_v_r <= 1'b1;
        free_r   <= rd_idx_r;
      end
      if (valid_r[rd_idx_r] && (!lru_v_r || rank_q > worst_r)) begin
        lru_v_r <= 1'b1;
        lru_r   <= rd_idx_r;
        worst_r <= rank_q;
      end
    end
    if (state_r == BK_DECIDE) begin
      upd_r  <= hit_r || (item_r.op == OP_PUT);
      fill_r <= !hit_r && fill_d;
      thr_r  <= hit_r ? found_rank_r : worst_r;
      if (hit_r) begin
        slot_r <= found_r;
      end else if (fill_d) begin
        slot_r <= free_r;
      end else begin
        slot_r <= lru_r;
      end
    end
    if (fin) begin
      out_r.hit        <= hit_r;
      out_r.read_value <= (item_r.op == OP_GET && hit_r) ? val_q : MISS_VALUE;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    key_q <= key_mem[cnt_r[IW-1:0]];
    if (fin && item_r.op == OP_PUT) begin
      key_mem[slot_r] <= item_r.key;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == BK_DECIDE) begin
      val_q <= val_mem[found_r];
    end
    if (fin && item_r.op == OP_PUT) begin
      val_mem[slot_r] <= item_r.write_value;
    end
  end

  always_ff @(posedge clk) begin
    rank_q <= rank_mem[cnt_r[IW-1:0]];
    if (rank_we) begin
      rank_mem[rank_wa] <= rank_wd;
    end
  end

endmodule

// File: src/lru_key_value_cache_core.sv
// channel | ports                          | handshake
// input   | in_valid, in_stall, in_data    | taken when valid and not stall
// result  | out_valid, out_stall, out_data | taken when valid and not stall
// config  | cfg_valid, cfg_ready, cfg_data | written when valid and ready
//
// Each item holds the back end from its take to its finish: a take step, one pass over
// the key and rank memories to find the hit, a free entry and the least recent entry,
// a decide step, a second pass over the rank memory to age ranks, and a finish.
// A two-item queue takes input while the back end works.
// Synchronous active-low reset empties the cache and sets capacity to 16.
// A result waiting on out_stall holds the back end in its last step.
module lru_key_value_cache_core #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  lkv_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output lkv_pkg::out_item_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_data
);
  import lkv_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);

  logic [CAP_W-1:0]   capacity_r;
  logic               q_valid, q_take;
  in_item_t           q_data;
  logic [CW-1:0]      bk_used;
  logic [ENTRIES-1:0] bk_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity_r <= cfg_data;
    end
  end

  lkv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_take   (q_take),
    .q_data   (q_data)
  );

  lkv_back #(.ENTRIES(ENTRIES)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_take      (q_take),
    .capacity    (capacity_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .used_count  (bk_used),
    .entry_valid (bk_valid)
  );

  a_used_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(bk_valid) == bk_used)
    else $error("used count differs from valid entries");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bk_used <= CW'(ENTRIES))
    else $error("used count beyond entries");

  a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.read_value == MISS_VALUE)
    else $error("miss result without all-ones value");

endmodule

// File: tb/testbench.sv
module testbench;
  import lkv_pkg::*;

  localparam int NUM_ENTRIES = ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 2 * NUM_ENTRIES + 20;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CAP_W-1:0] cfg_data;

  lru_key_value_cache_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // shadow of the cache contents
  logic [31:0] shadow_keys [NUM_ENTRIES];
  logic [31:0] shadow_values [NUM_ENTRIES];
  bit shadow_valid [NUM_ENTRIES];
  int shadow_rank [NUM_ENTRIES];
  int shadow_used;
  int shadow_capacity;

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  logic [31:0] key_pool [24];
  int send_idle_pct;
  int recv_stall_pct;
  int errors;
  int cycles;

  function automatic void promote(int idx, int old_rank);
    for (int i = 0; i < NUM_ENTRIES; i++)
      if (i != idx && shadow_valid[i] && shadow_rank[i] < old_rank) shadow_rank[i]++;
    shadow_rank[idx] = 0;
  endfunction

  function automatic out_item_t cache_access(in_item_t it);
    out_item_t res;
    int found;
    int slot;
    int worst;
    int eff_cap;
    found = -1;
    slot = -1;
    worst = -1;
    eff_cap = (shadow_capacity == 0) ? 1 :
              (shadow_capacity > NUM_ENTRIES) ? NUM_ENTRIES : shadow_capacity;
    for (int i = NUM_ENTRIES - 1; i >= 0; i--)
      if (shadow_valid[i] && shadow_keys[i] == it.key) found = i;
    res.hit = (found >= 0);
    res.read_value = MISS_VALUE;
    if (found >= 0) begin
      if (it.op == OP_GET) res.read_value = shadow_values[found];
      else shadow_values[found] = it.write_value;
      promote(found, shadow_rank[found]);
    end else if (it.op == OP_PUT) begin
      if (shadow_used < eff_cap)
        for (int i = NUM_ENTRIES - 1; i >= 0; i--)
          if (!shadow_valid[i]) slot = i;
      if (slot >= 0) begin
        for (int i = 0; i < NUM_ENTRIES; i++)
          if (shadow_valid[i]) shadow_rank[i]++;
        shadow_valid[slot] = 1;
        shadow_rank[slot] = 0;
        shadow_used++;
      end else begin
        // evict the least recent entry in place
        for (int i = 0; i < NUM_ENTRIES; i++)
          if (shadow_valid[i] && shadow_rank[i] > worst) begin
            worst = shadow_rank[i];
            slot = i;
          end
        promote(slot, worst);
      end
      shadow_keys[slot] = it.key;
      shadow_values[slot] = it.write_value;
    end
    return res;
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(cache_access(in_data));
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst_n) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result item hit=%0d read_value=%0d",
                 out_data.hit, out_data.read_value);
          errors++;
        end else begin
          exp_item = expected_results.pop_front();
          if (out_data.hit !== exp_item.hit) begin
            $error("hit: expected %0d, got %0d", exp_item.hit, out_data.hit);
            errors++;
          end
          if (out_data.read_value !== exp_item.read_value) begin
            $error("read_value: expected %0d, got %0d",
                   exp_item.read_value, out_data.read_value);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic in_item_t make_item(logic op, logic [31:0] key, logic [31:0] value);
    in_item_t it;
    it.op = op;
    it.key = key;
    it.write_value = value;
    return it;
  endfunction

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    wait_idle();
    cfg_data <= cap;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    shadow_capacity = cap;
    cfg_valid <= 0;
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0; recv_stall_pct = 0; end
      1: begin send_idle_pct = 46; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 46; end
      default: begin send_idle_pct = 37; recv_stall_pct = 37; end
    endcase
  endtask

  // pool size sets the hit rate against the capacity
  task automatic queue_random(int count, int pool_size);
    logic [31:0] key;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 88) key = key_pool[$urandom_range(pool_size - 1)];
      else key = $urandom;
      pending_items.push_back(make_item(1'($urandom_range(1)), key, $urandom));
    end
  endtask

  initial begin
    int caps [8];
    caps = '{16, 2, 0, 31, 1, 5, 16, 7};
    errors = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_data = '0;
    shadow_used = 0;
    shadow_capacity = CAP_RESET;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      shadow_valid[i] = 0;
      shadow_rank[i] = 0;
      shadow_keys[i] = '0;
      shadow_values[i] = '0;
    end
    for (int i = 0; i < 24; i++) key_pool[i] = $urandom;
    rst_n = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, get miss on empty cache, update, fill to full, eviction
    pending_items.push_back(make_item(OP_GET, 32'h0, 32'h0));
    pending_items.push_back(make_item(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF));
    pending_items.push_back(make_item(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000));
    pending_items.push_back(make_item(OP_PUT, 32'hFFFF_FFFF, 32'h0));
    pending_items.push_back(make_item(OP_GET, 32'h8000_0000, 32'h1234_5678));
    pending_items.push_back(make_item(OP_GET, 32'h7FFF_FFFF, 32'h0));
    pending_items.push_back(make_item(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(OP_GET, 32'hFFFF_FFFF, 32'h0));
    pending_items.push_back(make_item(OP_GET, 32'h0, 32'h0));
    for (int i = 0; i < 14; i++)
      pending_items.push_back(make_item(OP_PUT, i, ~i));
    pending_items.push_back(make_item(OP_PUT, 32'h5555_AAAA, 32'hAAAA_5555));
    pending_items.push_back(make_item(OP_GET, 32'h8000_0000, 32'h0));

    // shrink below the number in use, then walk through the other settings
    for (int ph = 0; ph < 8; ph++) begin
      write_capacity(caps[(ph + 1) % 8]);
      set_idling(ph);
      queue_random(185, (ph % 2 == 0) ? 20 : 6);
    end

    wait_idle();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

// File: filelist.f
src/lkv_pkg.sv
src/lkv_front.sv
src/lkv_back.sv
src/lru_key_value_cache_core.sv
tb/testbench.sv
